@@ src/dta_pkg.sv @@
// Shared types and constants for the dyadic transpose address generator.
// Used by every module in src; depends on nothing else.
`default_nettype none
package dta_pkg;

  // Fixed field widths.
  localparam int IDX_W    = 32;
  localparam int LEN_W    = 16;
  localparam int NUM_AXES = 4;
  localparam int AX_W     = 2;
  localparam int RANK_W   = 3;
  localparam int MAP_W    = 8;
  localparam int CNT_W    = 64;

  // Rank limit and usable length bits.
  localparam int MAX_RANK = 4;
  localparam int LEN_BITS = 16;
  localparam int RANK_CAP = (MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES;
  localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'((64'(1) << LEN_BITS) - 64'(1));

  // Division cells: one per quotient bit per result axis.
  localparam int NUM_CELLS = NUM_AXES * IDX_W;

  // Settling time of the derived configuration after a write.
  localparam logic [1:0] SETTLE_CYC = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_RANK = 3'd0;
  localparam logic [2:0] REG_MAP  = 3'd1;
  localparam logic [2:0] REG_LEN0 = 3'd2;
  localparam logic [2:0] REG_LEN1 = 3'd3;
  localparam logic [2:0] REG_LEN2 = 3'd4;
  localparam logic [2:0] REG_LEN3 = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_AXIS  = 2'd1,
    ST_GAP   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Values derived from the configuration registers.
  typedef struct packed {
    status_t                         cfg_status;
    logic [RANK_W-1:0]               rank;
    logic [MAP_W-1:0]                amap;
    logic [NUM_AXES-1:0][LEN_W-1:0]  zlen;
    logic [NUM_AXES-1:0][IDX_W-1:0]  sstride;
    logic [CNT_W-1:0]                count;
  } derive_t;

  // Item state handed from cell to cell.
  typedef struct packed {
    logic                            valid;
    logic                            beyond;
    logic [LEN_W-1:0]                rem;
    logic [IDX_W-1:0]                w;
    logic [NUM_AXES-1:0][LEN_W-1:0]  coord;
  } cell_t;

  // One finished result.
  typedef struct packed {
    logic [IDX_W-1:0] offset;
    logic [IDX_W-1:0] count;
    status_t          status;
  } res_t;

endpackage
`default_nettype wire

@@ src/dyadic_transpose_address_generator.sv @@
// Dyadic transpose address generator: one source offset per result index.
// Throughput: one item per cycle while the output queue has room and no configuration is
// settling. Items pass the 128-cell division chain, then the multiply, sum and queue stages.
// Reset (synchronous, active low) loads the identity map, rank 0, lengths 1, and
// holds the input off until the derived values settle; every configuration write also holds it off.
`default_nettype none
module dyadic_transpose_address_generator (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire [2:0]   cfg_index,
  input  wire [15:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [31:0]  in_result_index,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_source_offset,
  output logic [31:0] out_result_count,
  output logic [1:0]  out_status
);

  localparam int NC = dta_pkg::NUM_CELLS;

  dta_pkg::derive_t der;
  logic             busy;
  logic             en;
  logic             room;
  logic             in_xfer;

  dta_cfg_derive u_derive (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .der      (der),
    .busy     (busy)
  );

  // The whole pipe moves while the output queue has room.
  assign en       = room;
  assign in_stall = !en || busy;
  assign in_xfer  = in_valid && !in_stall;

  // Chain entry: range check against the unsaturated count.
  dta_pkg::cell_t chain [NC+1];

  always_comb begin
    chain[0].valid  = in_xfer;
    chain[0].beyond = (der.count[63:32] == 32'd0) && (in_result_index >= der.count[31:0]);
    chain[0].rem    = '0;
    chain[0].w      = in_result_index;
    chain[0].coord  = '0;
  end

  // Division cells, fastest result axis first.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    localparam int AX = dta_pkg::NUM_AXES - 1 - (k / dta_pkg::IDX_W);
    localparam bit LS = ((k % dta_pkg::IDX_W) == (dta_pkg::IDX_W - 1));
    dta_div_cell #(.AXIS(AX), .LAST(LS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .c_in   (chain[k]),
      .divisor(der.zlen[AX]),
      .c_out  (chain[k+1])
    );
  end

  // Multiply stage: stride times coordinate for each source axis.
  logic [dta_pkg::NUM_AXES-1:0][31:0] prod_r;
  logic [dta_pkg::NUM_AXES-1:0][47:0] prod_full;
  logic                               m_valid_r;
  logic                               m_beyond_r;
  dta_pkg::cell_t                     tail;

  assign tail = chain[NC];

  always_comb begin
    for (int i = 0; i < dta_pkg::NUM_AXES; i++) begin
      prod_full[i] = {16'd0, der.sstride[i]} * {32'd0, tail.coord[der.amap[2*i +: 2]]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_beyond_r <= tail.beyond;
      for (int i = 0; i < dta_pkg::NUM_AXES; i++) begin
        prod_r[i] <= (dta_pkg::RANK_W'(i) < der.rank) ? prod_full[i][31:0] : 32'd0;
      end
    end
  end

  // Sum stage and status selection.
  dta_pkg::res_t res;
  logic [31:0]   sum;
  logic [31:0]   cnt_sat;

  always_comb begin
    sum     = prod_r[0] + prod_r[1] + prod_r[2] + prod_r[3];
    cnt_sat = (der.count[63:32] != 32'd0) ? 32'hFFFF_FFFF : der.count[31:0];
    if (der.cfg_status != dta_pkg::ST_OK) begin
      res.status = der.cfg_status;
      res.offset = 32'd0;
      res.count  = 32'd0;
    end else if (m_beyond_r) begin
      res.status = dta_pkg::ST_RANGE;
      res.offset = 32'd0;
      res.count  = cnt_sat;
    end else begin
      res.status = dta_pkg::ST_OK;
      res.offset = sum;
      res.count  = cnt_sat;
    end
  end

  dta_pkg::res_t s_res_r;
  logic          s_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (en) begin
      s_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) s_res_r <= res;
  end

  // Output queue.
  dta_pkg::res_t q_out;

  dta_out_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (en && s_valid_r),
    .push_data(s_res_r),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (q_out)
  );

  assign out_source_offset = q_out.offset;
  assign out_result_count  = q_out.count;
  assign out_status        = q_out.status;

endmodule
`default_nettype wire

@@ src/dta_div_cell.sv @@
// One restoring-division step of the coordinate chain.
// Depends on dta_pkg.
`default_nettype none
module dta_div_cell #(
  parameter int AXIS = 0,
  parameter bit LAST = 1'b0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire dta_pkg::cell_t          c_in,
  input  wire [dta_pkg::LEN_W-1:0]     divisor,
  output dta_pkg::cell_t               c_out
);

  dta_pkg::cell_t              c_r;
  dta_pkg::cell_t              c_nxt;
  logic [dta_pkg::LEN_W:0]     trial;
  logic [dta_pkg::LEN_W:0]     diff;
  logic                        ge;
  logic [dta_pkg::LEN_W-1:0]   rem_new;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial   = {c_in.rem, c_in.w[dta_pkg::IDX_W-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    rem_new = ge ? diff[dta_pkg::LEN_W-1:0] : trial[dta_pkg::LEN_W-1:0];
    c_nxt   = c_in;
    c_nxt.w = {c_in.w[dta_pkg::IDX_W-2:0], ge};
    if (LAST) begin
      // The last step of an axis leaves its coordinate and restarts the remainder.
      c_nxt.coord[AXIS] = rem_new;
      c_nxt.rem         = '0;
    end else begin
      c_nxt.rem = rem_new;
    end
  end

  // Reset clears only the valid bit; the payload moves with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.valid <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule
`default_nettype wire

@@ src/dta_cfg_derive.sv @@
// Configuration registers and the registered derivation of lengths, strides and count.
// Depends on dta_pkg.
`default_nettype none
module dta_cfg_derive (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire [2:0]          cfg_index,
  input  wire [15:0]         cfg_data,
  output dta_pkg::derive_t   der,
  output logic               busy
);

  logic [dta_pkg::RANK_W-1:0]                    rank_r;
  logic [dta_pkg::MAP_W-1:0]                     map_r;
  logic [dta_pkg::NUM_AXES-1:0][dta_pkg::LEN_W-1:0] len_r;
  logic [1:0]                                    settle_r;
  logic [1:0]                                    settle_nxt;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
      map_r  <= 8'd228;
      len_r  <= {dta_pkg::NUM_AXES{16'd1}};
    end else if (cfg_we) begin
      case (cfg_index)
        dta_pkg::REG_RANK: rank_r   <= cfg_data[2:0];
        dta_pkg::REG_MAP:  map_r    <= cfg_data[7:0];
        dta_pkg::REG_LEN0: len_r[0] <= cfg_data;
        dta_pkg::REG_LEN1: len_r[1] <= cfg_data;
        dta_pkg::REG_LEN2: len_r[2] <= cfg_data;
        dta_pkg::REG_LEN3: len_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Settle counter: holds the input off until the derived values are current.
  always_comb begin
    if (cfg_we) begin
      settle_nxt = dta_pkg::SETTLE_CYC;
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= dta_pkg::SETTLE_CYC;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  assign busy = (settle_r != 2'd0);

  // First stage: map check, result lengths and effective source lengths.
  logic [dta_pkg::RANK_W-1:0]                       r_eff;
  logic [dta_pkg::NUM_AXES-1:0]                     act;
  logic [dta_pkg::NUM_AXES-1:0][dta_pkg::AX_W-1:0]  am;
  logic [dta_pkg::NUM_AXES-1:0]                     used;
  logic [dta_pkg::NUM_AXES-1:0][dta_pkg::LEN_W-1:0] len_m;
  logic [dta_pkg::NUM_AXES-1:0][dta_pkg::LEN_W-1:0] zl;
  logic [dta_pkg::NUM_AXES-1:0][dta_pkg::LEN_W-1:0] sl;
  logic                                             axis_err;
  logic                                             gap_err;
  logic                                             above;
  dta_pkg::status_t                                 st;

  always_comb begin
    r_eff    = (rank_r > dta_pkg::RANK_W'(dta_pkg::RANK_CAP)) ?
               dta_pkg::RANK_W'(dta_pkg::RANK_CAP) : rank_r;
    axis_err = 1'b0;
    used     = '0;
    for (int i = 0; i < dta_pkg::NUM_AXES; i++) begin
      am[i]    = map_r[2*i +: 2];
      act[i]   = (dta_pkg::RANK_W'(i) < r_eff);
      len_m[i] = len_r[i] & dta_pkg::LEN_MASK;
      sl[i]    = act[i] ? len_m[i] : 16'd1;
      if (act[i] && ({1'b0, am[i]} >= r_eff)) axis_err = 1'b1;
      if (act[i]) used[am[i]] = 1'b1;
    end
    for (int a = 0; a < dta_pkg::NUM_AXES; a++) begin
      zl[a] = {dta_pkg::LEN_W{1'b1}};
      for (int i = 0; i < dta_pkg::NUM_AXES; i++) begin
        if (act[i] && (am[i] == dta_pkg::AX_W'(a)) && (len_m[i] < zl[a])) zl[a] = len_m[i];
      end
      if (!used[a]) zl[a] = 16'd1;
    end
    // A gap is an unused axis with a used axis above it.
    gap_err = 1'b0;
    above   = 1'b0;
    for (int a = dta_pkg::NUM_AXES - 1; a >= 0; a--) begin
      if (!used[a] && above) gap_err = 1'b1;
      if (used[a]) above = 1'b1;
    end
    if (axis_err) begin
      st = dta_pkg::ST_AXIS;
    end else if (gap_err) begin
      st = dta_pkg::ST_GAP;
    end else begin
      st = dta_pkg::ST_OK;
    end
  end

  dta_pkg::status_t                                 st_r;
  logic [dta_pkg::RANK_W-1:0]                       r_r;
  logic [dta_pkg::MAP_W-1:0]                        am_r;
  logic [dta_pkg::NUM_AXES-1:0][dta_pkg::LEN_W-1:0] zl_r;
  logic [dta_pkg::NUM_AXES-1:0][dta_pkg::LEN_W-1:0] sl_r;
  logic [31:0]                                      p01_r;
  logic [31:0]                                      p23_r;
  logic [31:0]                                      ss1_r;
  logic [31:0]                                      ss0_r;
  logic [dta_pkg::CNT_W-1:0]                        count_r;
  logic [47:0]                                      ss0_full;

  assign ss0_full = {32'd0, sl_r[1]} * {16'd0, ss1_r};

  // First-stage registers, then the second and third stages: at most one multiply per register.
  always_ff @(posedge clk) begin
    st_r    <= st;
    r_r     <= r_eff;
    am_r    <= map_r;
    zl_r    <= zl;
    sl_r    <= sl;
    p01_r   <= {16'd0, zl_r[0]} * {16'd0, zl_r[1]};
    p23_r   <= {16'd0, zl_r[2]} * {16'd0, zl_r[3]};
    ss1_r   <= {16'd0, sl_r[2]} * {16'd0, sl_r[3]};
    ss0_r   <= ss0_full[31:0];
    count_r <= {32'd0, p01_r} * {32'd0, p23_r};
  end

  always_comb begin
    der.cfg_status = st_r;
    der.rank       = r_r;
    der.amap       = am_r;
    der.zlen       = zl_r;
    der.sstride[0] = ss0_r;
    der.sstride[1] = ss1_r;
    der.sstride[2] = {16'd0, sl_r[3]};
    der.sstride[3] = 32'd1;
    der.count      = count_r;
  end

endmodule
`default_nettype wire

@@ src/dta_out_skid.sv @@
// Two-entry output queue that parts the pipeline from the result channel.
// Depends on dta_pkg.
`default_nettype none
module dta_out_skid (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire dta_pkg::res_t push_data,
  output logic             room,
  output logic             out_valid,
  input  wire              out_stall,
  output dta_pkg::res_t    out_data
);

  dta_pkg::res_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r != 2'd2);
  assign out_data  = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire
